// ===== rtl/core/kagbf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kagbf_pkg;

    localparam int FX_W = 32;
    localparam logic signed [FX_W-1:0] FX_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [FX_W-1:0] FX_MIN = 32'sh8000_0000;

    // config register indexes
    localparam logic [1:0] CFG_PERIOD = 2'd0;
    localparam logic [1:0] CFG_QA     = 2'd1;
    localparam logic [1:0] CFG_QB     = 2'd2;
    localparam logic [1:0] CFG_R      = 2'd3;

    localparam int PERIOD_W = 17;
    localparam int QA_W     = 16;
    localparam int QB_W     = 16;
    localparam int R_W      = 24;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = 17'd328;
    localparam logic [QA_W-1:0]     QA_RST     = 16'd66;
    localparam logic [QB_W-1:0]     QB_RST     = 16'd328;
    localparam logic [R_W-1:0]      R_RST      = 24'd32768;

    typedef struct packed {
        logic                    start;
        logic signed [FX_W-1:0]  num0;
        logic signed [FX_W-1:0]  num1;
        logic signed [FX_W-1:0]  den;
    } t_div_req;

    function automatic logic signed [FX_W-1:0] sat_add(
        input logic signed [FX_W-1:0] a,
        input logic signed [FX_W-1:0] b
    );
        logic signed [FX_W:0] s;
        s = {a[FX_W-1], a} + {b[FX_W-1], b};
        if (s[FX_W] != s[FX_W-1]) begin
            return s[FX_W] ? FX_MIN : FX_MAX;
        end
        return s[FX_W-1:0];
    endfunction

    function automatic logic signed [FX_W-1:0] sat_sub(
        input logic signed [FX_W-1:0] a,
        input logic signed [FX_W-1:0] b
    );
        logic signed [FX_W:0] s;
        s = {a[FX_W-1], a} - {b[FX_W-1], b};
        if (s[FX_W] != s[FX_W-1]) begin
            return s[FX_W] ? FX_MIN : FX_MAX;
        end
        return s[FX_W-1:0];
    endfunction

    function automatic logic signed [FX_W-1:0] sat_neg(input logic signed [FX_W-1:0] a);
        if (a == FX_MIN) begin
            return FX_MAX;
        end
        return -a;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/kagbf_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Shared fixed-point multiplier: operand regs, product reg, round/saturate reg.
module kagbf_mul #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [31:0]   i_a,
    input  wire logic signed [31:0]   i_b,
    output logic                      o_done,
    output logic signed [31:0]        o_res
);
    import kagbf_pkg::*;

    localparam logic signed [63:0] RND = 64'sd1 <<< (FRAC_BITS - 1);

    logic signed [31:0] r_a, r_b;
    logic signed [63:0] r_p;
    logic signed [31:0] r_res;
    logic [2:0]         r_v;
    logic signed [63:0] n_sum;
    logic signed [63:0] n_sh;
    logic signed [31:0] n_res;

    always_comb begin
        n_sum = r_p + RND;
        n_sh  = n_sum >>> FRAC_BITS;
        // in range when bits 63..31 are all copies of the sign
        if ((&n_sh[63:31]) || !(|n_sh[63:31])) begin
            n_res = n_sh[31:0];
        end else begin
            n_res = n_sh[63] ? FX_MIN : FX_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_start};
        end
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        r_p   <= r_a * r_b;
        r_res <= n_res;
    end

    assign o_done = r_v[2];
    assign o_res  = r_res;

endmodule

`default_nettype wire

// ===== rtl/core/kagbf_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Two-lane restoring divider sharing one denominator: q = (num << FRAC_BITS) / den,
// truncated toward zero, saturated. One quotient bit per lane per cycle.
module kagbf_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  kagbf_pkg::t_div_req      i_req,
    output logic                     o_done,
    output logic signed [31:0]       o_q0,
    output logic signed [31:0]       o_q1
);
    import kagbf_pkg::*;

    localparam int DW = 32 + FRAC_BITS;
    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_fin;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [31:0]   r_den;
    logic          r_den_neg;
    logic          r_den_zero;
    logic [1:0]    r_num_neg;
    logic [1:0]    r_num_zero;
    logic [31:0]   r_rem [2];
    logic [DW-1:0] r_quo [2];
    logic signed [31:0] r_q [2];

    logic [32:0]   n_shift [2];
    logic          n_ge    [2];
    logic [32:0]   n_diff  [2];
    logic signed [31:0] n_q [2];
    logic [31:0]   n_nmag  [2];
    logic signed [31:0] n_num [2];
    logic [31:0]   n_dmag;
    logic          n_neg   [2];

    always_comb begin
        n_num[0] = i_req.num0;
        n_num[1] = i_req.num1;
        n_dmag   = i_req.den[31] ? (~i_req.den + 32'd1) : i_req.den;
        for (int l = 0; l < 2; l++) begin
            n_nmag[l]  = n_num[l][31] ? (~n_num[l] + 32'd1) : n_num[l];
            n_shift[l] = {r_rem[l], r_quo[l][DW-1]};
            n_diff[l]  = n_shift[l] - {1'b0, r_den};
            n_ge[l]    = !n_diff[l][32];
            n_neg[l]   = r_num_neg[l] ^ r_den_neg;
            if (r_den_zero) begin
                if (r_num_zero[l]) begin
                    n_q[l] = '0;
                end else begin
                    n_q[l] = r_num_neg[l] ? FX_MIN : FX_MAX;
                end
            end else if (!n_neg[l]) begin
                n_q[l] = (|r_quo[l][DW-1:31]) ? FX_MAX : r_quo[l][31:0];
            end else if ((|r_quo[l][DW-1:32]) || (r_quo[l][31] && (|r_quo[l][30:0]))) begin
                n_q[l] = FX_MIN;
            end else begin
                n_q[l] = -r_quo[l][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CW'(1))) begin
                r_busy <= 1'b0;
                r_fin  <= 1'b1;
            end
        end
        if (i_req.start) begin
            r_cnt      <= CW'(DW);
            r_den      <= n_dmag;
            r_den_neg  <= i_req.den[31];
            r_den_zero <= (i_req.den == '0);
            for (int l = 0; l < 2; l++) begin
                r_num_neg[l]  <= n_num[l][31];
                r_num_zero[l] <= (n_num[l] == '0);
                r_rem[l]      <= '0;
                r_quo[l]      <= {n_nmag[l], {FRAC_BITS{1'b0}}};
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            for (int l = 0; l < 2; l++) begin
                r_rem[l] <= n_ge[l] ? n_diff[l][31:0] : n_shift[l][31:0];
                r_quo[l] <= {r_quo[l][DW-2:0], n_ge[l]};
            end
        end
        if (r_fin) begin
            r_q[0] <= n_q[0];
            r_q[1] <= n_q[1];
        end
    end

    assign o_done = r_done;
    assign o_q0   = r_q[0];
    assign o_q1   = r_q[1];

endmodule

`default_nettype wire

// ===== rtl/core/kalman_angle_gyro_bias_fusion_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel     Direction  Word
// s_axis      in         tdata[24:0] angle_meas, [52:25] gyro_rate
// m_axis      out        tdata[31:0] angle_est, [63:32] rate_est, [95:64] bias_est
// cfg         in         we / idx / data, write only
//
// Each sample runs ten multiplies on the shared multiplier (four before and six after the
// divide), one (32 + FRAC_BITS)-step two-lane divide for both gains, and a load of the
// output register. tready is high only while idle.
// A finished word waits in the output register; the next sample is taken meanwhile,
// and its result holds in the last state until the pending word leaves.
// Synchronous active-low reset restores the register defaults and identity covariance.
module kalman_angle_gyro_bias_fusion_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  wire logic [55:0]   i_s_axis_tdata,   // angle_meas, gyro_rate
    output logic               o_m_axis_tvalid,
    input  wire logic          i_m_axis_tready,
    output logic [95:0]        o_m_axis_tdata,   // angle_est, rate_est, bias_est
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_idx,
    input  wire logic [23:0]   i_cfg_data
);
    import kagbf_pkg::*;

    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ISSUE = 5'b00010,
        S_WAIT  = 5'b00100,
        S_DIV   = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    typedef enum logic [3:0] {
        OP_PRED_ANGLE,
        OP_PRED_P00,
        OP_PRED_P01,
        OP_PRED_P11,
        OP_CORR_P10,
        OP_CORR_P11,
        OP_CORR_P01,
        OP_CORR_P00,
        OP_CORR_ANGLE,
        OP_CORR_BIAS
    } t_op;

    t_state r_state, n_state;
    t_op    r_op;

    logic [PERIOD_W-1:0] r_dt;
    logic [QA_W-1:0]     r_qa;
    logic [QB_W-1:0]     r_qb;
    logic [R_W-1:0]      r_r;

    logic signed [31:0] r_angle, r_bias;
    logic signed [31:0] r_p00, r_p01, r_p10, r_p11;
    logic signed [31:0] r_meas, r_gyro, r_err, r_e, r_k0, r_k1, r_tmp;

    logic               r_out_valid;
    logic signed [31:0] r_out_angle, r_out_rate, r_out_bias;

    logic signed [31:0] dt_x, qa_x, qb_x, r_x;
    logic signed [31:0] in_meas, in_gyro;
    logic signed [31:0] mul_a, mul_b, mul_res;
    logic               mul_start, mul_done;
    logic               div_done;
    logic signed [31:0] div_q0, div_q1;
    t_div_req           div_req;
    logic               wb;
    logic               out_free;

    assign dt_x    = $signed({{(32 - PERIOD_W){1'b0}}, r_dt});
    assign qa_x    = $signed({{(32 - QA_W){1'b0}}, r_qa});
    assign qb_x    = $signed({{(32 - QB_W){1'b0}}, r_qb});
    assign r_x     = $signed({{(32 - R_W){1'b0}}, r_r});
    assign in_meas = $signed({{7{i_s_axis_tdata[24]}}, i_s_axis_tdata[24:0]});
    assign in_gyro = $signed({{4{i_s_axis_tdata[52]}}, i_s_axis_tdata[52:25]});

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign mul_start       = (r_state == S_ISSUE);
    assign wb              = (r_state == S_WAIT) && mul_done;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    always_comb begin
        div_req.start = wb && (r_op == OP_PRED_P11);
        div_req.num0  = r_p00;
        div_req.num1  = r_p10;
        div_req.den   = r_e;
    end

    always_comb begin
        unique case (r_op)
            OP_PRED_ANGLE: begin mul_a = sat_sub(r_gyro, r_bias); mul_b = dt_x;  end
            OP_PRED_P00:   begin mul_a = sat_sub(r_tmp, r_p10);   mul_b = dt_x;  end
            OP_PRED_P01:   begin mul_a = sat_neg(r_p11);          mul_b = dt_x;  end
            OP_PRED_P11:   begin mul_a = qb_x;                    mul_b = dt_x;  end
            OP_CORR_P10:   begin mul_a = r_k1;                    mul_b = r_p00; end
            OP_CORR_P11:   begin mul_a = r_k1;                    mul_b = r_p01; end
            OP_CORR_P01:   begin mul_a = r_k0;                    mul_b = r_p01; end
            OP_CORR_P00:   begin mul_a = r_k0;                    mul_b = r_p00; end
            OP_CORR_ANGLE: begin mul_a = r_k0;                    mul_b = r_err; end
            OP_CORR_BIAS:  begin mul_a = r_k1;                    mul_b = r_err; end
            default:       begin mul_a = '0;                      mul_b = '0;    end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_s_axis_tvalid) n_state = S_ISSUE;
            S_ISSUE: n_state = S_WAIT;
            S_WAIT: begin
                if (mul_done) begin
                    if (r_op == OP_PRED_P11) begin
                        n_state = S_DIV;
                    end else if (r_op == OP_CORR_BIAS) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_ISSUE;
                    end
                end
            end
            S_DIV:   if (div_done) n_state = S_ISSUE;
            S_FIN:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_PRED_ANGLE;
            r_out_valid <= 1'b0;
            r_dt        <= PERIOD_RST;
            r_qa        <= QA_RST;
            r_qb        <= QB_RST;
            r_r         <= R_RST;
            r_angle     <= '0;
            r_bias      <= '0;
            r_p00       <= ONE;
            r_p01       <= '0;
            r_p10       <= '0;
            r_p11       <= ONE;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_PERIOD: r_dt <= i_cfg_data[PERIOD_W-1:0];
                    CFG_QA:     r_qa <= i_cfg_data[QA_W-1:0];
                    CFG_QB:     r_qb <= i_cfg_data[QB_W-1:0];
                    CFG_R:      r_r  <= i_cfg_data[R_W-1:0];
                    default:    ;
                endcase
            end

            if (r_state == S_IDLE && i_s_axis_tvalid) begin
                r_op <= OP_PRED_ANGLE;
            end else if (wb && r_op != OP_PRED_P11 && r_op != OP_CORR_BIAS) begin
                r_op <= t_op'(r_op + 4'd1);
            end else if (r_state == S_DIV && div_done) begin
                r_op <= OP_CORR_P10;
            end

            if (wb) begin
                unique case (r_op)
                    OP_PRED_ANGLE: r_angle <= sat_add(r_angle, mul_res);
                    OP_PRED_P00:   r_p00   <= sat_add(r_p00, mul_res);
                    OP_PRED_P01: begin
                        // same dt * -P11 term lands on both off-diagonals
                        r_p01 <= sat_add(r_p01, mul_res);
                        r_p10 <= sat_add(r_p10, mul_res);
                    end
                    OP_PRED_P11:   r_p11   <= sat_add(r_p11, mul_res);
                    OP_CORR_P10:   r_p10   <= sat_sub(r_p10, mul_res);
                    OP_CORR_P11:   r_p11   <= sat_sub(r_p11, mul_res);
                    OP_CORR_P01:   r_p01   <= sat_sub(r_p01, mul_res);
                    OP_CORR_P00:   r_p00   <= sat_sub(r_p00, mul_res);
                    OP_CORR_ANGLE: r_angle <= sat_add(r_angle, mul_res);
                    OP_CORR_BIAS:  r_bias  <= sat_add(r_bias, mul_res);
                    default:       ;
                endcase
            end

            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_m_axis_tvalid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end

        // datapath temporaries, no reset needed
        if (r_state == S_IDLE && i_s_axis_tvalid) begin
            r_meas <= in_meas;
            r_gyro <= in_gyro;
            r_tmp  <= sat_sub(qa_x, r_p01);
        end
        if (wb && r_op == OP_PRED_P00) begin
            // angle already holds the prediction here
            r_err <= sat_sub(r_meas, r_angle);
        end
        if (wb && r_op == OP_PRED_P01) begin
            r_e <= sat_add(r_x, r_p00);
        end
        if (r_state == S_DIV && div_done) begin
            r_k0 <= div_q0;
            r_k1 <= div_q1;
        end
        if (r_state == S_FIN && out_free) begin
            r_out_angle <= r_angle;
            r_out_rate  <= sat_sub(r_gyro, r_bias);
            r_out_bias  <= r_bias;
        end
    end

    kagbf_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    kagbf_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_q0    (div_q0),
        .o_q1    (div_q1)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_bias, r_out_rate, r_out_angle};

`ifndef SYNTHESIS
    a_mul_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_WAIT))
        else $error("multiplier result outside wait state");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider result outside divide state");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=>
            (r_state == S_ISSUE && r_op == OP_PRED_ANGLE))
        else $error("accepted word did not start the sequence");

    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_out_valid && !i_m_axis_tready) |=> (r_state == S_FIN))
        else $error("result overwrote a pending output word");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import kagbf_pkg::*;

    localparam int FRAC          = 16;
    localparam int ANG_LIM       = 11796480;    // 180 deg
    localparam int GYRO_LIM      = 131072000;   // 2000 deg/s
    localparam int NOISE         = 131072;
    localparam int GYRO_OFS      = 196608;
    localparam int SETTLE_CYCLES = 200;
    localparam int PHASES        = 6;
    localparam int PHASE_WORDS   = 125;

    typedef struct packed {
        logic [31:0] angle_est;
        logic [31:0] rate_est;
        logic [31:0] bias_est;
    } fusion_out_t;

    class angle_tracker;
        logic [PERIOD_W-1:0] period;
        logic [QA_W-1:0]     qa;
        logic [QB_W-1:0]     qb;
        logic [R_W-1:0]      r;
        int                  angle;
        int                  bias;
        int                  cov [4];
        fusion_out_t         pending_est [$];
        int                  errors;

        function new();
            period = PERIOD_RST;
            qa     = QA_RST;
            qb     = QB_RST;
            r      = R_RST;
            angle  = 0;
            bias   = 0;
            cov    = '{1 << FRAC, 0, 0, 1 << FRAC};
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [23:0] data);
            case (idx)
                CFG_PERIOD: period = data[PERIOD_W-1:0];
                CFG_QA:     qa     = data[QA_W-1:0];
                CFG_QB:     qb     = data[QB_W-1:0];
                CFG_R:      r      = data[R_W-1:0];
                default: ;
            endcase
        endfunction

        function int clamp(longint v);
            if (v > longint'(FX_MAX)) return FX_MAX;
            if (v < longint'(FX_MIN)) return FX_MIN;
            return int'(v);
        endfunction

        function int qadd(int a, int b);
            return clamp(longint'(a) + longint'(b));
        endfunction

        function int qsub(int a, int b);
            return clamp(longint'(a) - longint'(b));
        endfunction

        function int qneg(int a);
            return clamp(-longint'(a));
        endfunction

        // round half up, then saturate
        function int qmul(int a, int b);
            longint p;
            p = longint'(a) * longint'(b) + (longint'(1) <<< (FRAC - 1));
            return clamp(p >>> FRAC);
        endfunction

        function int qdiv(int num, int den);
            longint n;
            if (den == 0) begin
                if (num > 0) return FX_MAX;
                if (num < 0) return FX_MIN;
                return 0;
            end
            n = longint'(num) <<< FRAC;
            return clamp(n / longint'(den));
        endfunction

        function void take_sample(logic [24:0] meas_bits, logic [27:0] gyro_bits);
            int meas, gyro, dt, p00, p01, p10, p11, d0, d12, err, e, k0, k1, t0, t1;
            fusion_out_t res;
            meas = $signed(meas_bits);
            gyro = $signed(gyro_bits);
            dt   = int'(period);

            angle = qadd(angle, qmul(qsub(gyro, bias), dt));
            err   = qsub(meas, angle);

            p00 = cov[0];
            p01 = cov[1];
            p10 = cov[2];
            p11 = cov[3];
            d0  = qsub(qsub(int'(qa), p01), p10);
            d12 = qneg(p11);
            p00 = qadd(p00, qmul(d0, dt));
            p01 = qadd(p01, qmul(d12, dt));
            p10 = qadd(p10, qmul(d12, dt));
            p11 = qadd(p11, qmul(int'(qb), dt));

            e  = qadd(int'(r), p00);
            k0 = qdiv(p00, e);
            k1 = qdiv(p10, e);

            t0  = p00;
            t1  = p01;
            p00 = qsub(p00, qmul(k0, t0));
            p01 = qsub(p01, qmul(k0, t1));
            p10 = qsub(p10, qmul(k1, t0));
            p11 = qsub(p11, qmul(k1, t1));
            cov = '{p00, p01, p10, p11};

            angle = qadd(angle, qmul(k0, err));
            bias  = qadd(bias, qmul(k1, err));

            res.angle_est = angle;
            res.rate_est  = qsub(gyro, bias);
            res.bias_est  = bias;
            pending_est.push_back(res);
        endfunction

        task report(string msg);
            if (errors < 40) $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_est(logic [95:0] word);
            fusion_out_t want;
            if (pending_est.size() == 0) begin
                report($sformatf("output word %h with no sample pending", word));
                return;
            end
            want = pending_est.pop_front();
            if (word[31:0] !== want.angle_est)
                report($sformatf("angle_est got %h want %h", word[31:0], want.angle_est));
            if (word[63:32] !== want.rate_est)
                report($sformatf("rate_est got %h want %h", word[63:32], want.rate_est));
            if (word[95:64] !== want.bias_est)
                report($sformatf("bias_est got %h want %h", word[95:64], want.bias_est));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [55:0] i_s_axis_tdata  = '0;    // angle_meas, gyro_rate
    logic        i_m_axis_tready = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic [1:0]  i_cfg_idx       = CFG_PERIOD;
    logic [23:0] i_cfg_data      = '0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [95:0] o_m_axis_tdata;          // angle_est, rate_est, bias_est

    angle_tracker tracker = new();

    int send_idle_pct = 28;
    int recv_idle_pct = 69;
    bit hold_req      = 1'b0;
    int hold_left     = 0;
    int trk_angle     = 0;
    int trk_rate      = 0;

    kalman_angle_gyro_bias_fusion_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("TIMEOUT: results still outstanding");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: check accepted words, then pick next tready
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                tracker.check_est(o_m_axis_tdata);
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_sample(input logic [24:0] meas, input logic [27:0] gyro);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {3'b000, gyro, meas};
        do @(posedge i_clk); while (!o_s_axis_tready);
        tracker.take_sample(meas, gyro);
    endtask

    task automatic send_random();
        logic [24:0] meas;
        logic [27:0] gyro;
        int          sel;
        sel = $urandom_range(99);
        if (sel < 70) begin
            // plausible motion: slowly changing rate, constant gyro offset, noise
            if ($urandom_range(15) == 0) begin
                trk_rate = int'($urandom_range(0, GYRO_LIM / 5)) - GYRO_LIM / 10;
            end
            trk_angle += trk_rate / 100;
            if (trk_angle > ANG_LIM || trk_angle < -ANG_LIM) trk_angle = 0;
            meas = 25'(trk_angle + int'($urandom_range(0, 2 * NOISE)) - NOISE);
            gyro = 28'(trk_rate + GYRO_OFS + int'($urandom_range(0, 2 * NOISE)) - NOISE);
        end else if (sel < 85) begin
            meas = 25'($urandom);
            gyro = 28'($urandom);
        end else begin
            case ($urandom_range(4))
                0: meas = 25'(ANG_LIM);
                1: meas = 25'(-ANG_LIM);
                2: meas = 25'h0FF_FFFF;
                3: meas = 25'h100_0000;
                default: meas = '0;
            endcase
            case ($urandom_range(4))
                0: gyro = 28'(GYRO_LIM);
                1: gyro = 28'(-GYRO_LIM);
                2: gyro = 28'h7FF_FFFF;
                3: gyro = 28'h800_0000;
                default: gyro = '0;
            endcase
        end
        send_sample(meas, gyro);
    endtask

    task automatic drain_pause();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending_est.size() != 0);
    endtask

    task automatic settle();
        drain_pause();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_all(input logic [23:0] period, input logic [23:0] qa,
                           input logic [23:0] qb, input logic [23:0] r);
        logic [1:0]  idxs [4];
        logic [23:0] vals [4];
        idxs = '{CFG_PERIOD, CFG_QA, CFG_QB, CFG_R};
        vals = '{period, qa, qb, r};
        foreach (idxs[i]) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idxs[i];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            tracker.write_reg(idxs[i], vals[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [23:0] pick_reg(int unsigned hi, logic [23:0] all_ones);
        case ($urandom_range(7))
            0: return '0;
            1: return 24'(hi);
            2: return all_ones;
            3: return 24'd1;
            4, 5: return 24'($urandom_range(1, 2000));
            default: return 24'($urandom_range(1, hi));
        endcase
    endfunction

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: field and range extremes
        send_sample('0, '0);
        send_sample(25'(ANG_LIM), '0);
        send_sample(25'(-ANG_LIM), '0);
        send_sample('0, 28'(GYRO_LIM));
        send_sample('0, 28'(-GYRO_LIM));
        send_sample(25'h0FF_FFFF, 28'h7FF_FFFF);
        send_sample(25'h100_0000, 28'h800_0000);
        send_sample(25'(65536), 28'(GYRO_OFS));
        send_sample(25'(-65536), 28'(-GYRO_OFS));

        // zero noise: gain goes to one, then the innovation variance hits zero
        settle();
        cfg_all(24'd328, '0, '0, '0);
        send_sample('0, '0);
        send_sample('0, '0);
        send_sample(25'(65536), '0);
        send_sample(25'(-65536), '0);
        send_sample('0, 28'(65536 * 10));

        // all data bits set: widest dt and noises, drive everything into saturation
        settle();
        cfg_all(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
        repeat (6) send_sample(25'h0FF_FFFF, 28'h7FF_FFFF);
        repeat (4) send_sample(25'h100_0000, 28'h800_0000);

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph / 2)
                0: begin
                    send_idle_pct = 28;
                    recv_idle_pct = 69;
                end
                1: begin
                    send_idle_pct = 69;
                    recv_idle_pct = 28;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (ph == 0) begin
                cfg_all(24'(PERIOD_RST), 24'(QA_RST), 24'(QB_RST), 24'(R_RST));
            end else begin
                cfg_all(pick_reg(65536, 24'hFF_FFFF), pick_reg(65535, 24'h00_FFFF),
                        pick_reg(65535, 24'h00_FFFF), pick_reg(16777215, 24'hFF_FFFF));
            end
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (n == 30 && (ph == 0 || ph == 4)) hold_req = 1'b1;
                if (n == 70) drain_pause();
                send_random();
            end
        end

        settle();
        if (tracker.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
